// ===== src/epr_pkg.sv =====
// ----------------------------------------------------------------------------
// epr_pkg
// Shared constants, widths and arithmetic helpers for the point rotation core.
// ----------------------------------------------------------------------------
package epr_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int NUM_STAGES    = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  localparam int ANG_W = 16;
  localparam int PT_W  = 32;
  localparam int AW    = 36;   // cordic angle accumulator
  localparam int QW    = 34;   // Q.30 sine, cosine and quaternion parts
  localparam int TW    = 35;   // intermediate product q*p, Q16.16
  localparam int RW    = 72;   // rounding width

  localparam logic signed [AW-1:0] Q30_PI      = AW'(64'sd3373259426);
  localparam logic signed [AW-1:0] Q30_HALF_PI = AW'(64'sd1686629713);
  localparam logic signed [QW-1:0] Q30_GAIN    = QW'(64'sd652032874);

  function automatic logic signed [AW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [AW-1:0] r;
    unique case (idx)
      5'd0:  r = AW'(64'sd843314857);
      5'd1:  r = AW'(64'sd497837829);
      5'd2:  r = AW'(64'sd263043837);
      5'd3:  r = AW'(64'sd133525159);
      5'd4:  r = AW'(64'sd67021687);
      5'd5:  r = AW'(64'sd33543516);
      5'd6:  r = AW'(64'sd16775851);
      5'd7:  r = AW'(64'sd8388437);
      5'd8:  r = AW'(64'sd4194283);
      5'd9:  r = AW'(64'sd2097149);
      5'd31: r = '0;
      default: r = AW'(64'sd1) <<< (5'd30 - idx);
    endcase
    return r;
  endfunction

  // round half up and drop 30 fraction bits
  function automatic logic signed [RW-1:0] round30(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] s;
    s = v + (RW'(1) <<< 29);
    return s >>> 30;
  endfunction

  function automatic logic signed [PT_W-1:0] sat32(input logic signed [RW-1:0] v);
    logic signed [PT_W-1:0] r;
    if (v > RW'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (v < -RW'(64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = v[PT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/epr_if.sv =====
// ----------------------------------------------------------------------------
// epr_if
// Valid/ready channels carrying the angle/point words and the result words.
// ----------------------------------------------------------------------------
interface epr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [epr_pkg::ANG_W-1:0]     roll;
  logic signed [epr_pkg::ANG_W-1:0]     pitch;
  logic signed [epr_pkg::ANG_W-1:0]     yaw;
  logic signed [epr_pkg::PT_W-1:0]      point_x;
  logic signed [epr_pkg::PT_W-1:0]      point_y;
  logic signed [epr_pkg::PT_W-1:0]      point_z;
  modport source (output valid, roll, pitch, yaw, point_x, point_y, point_z, input ready);
  modport sink   (input valid, roll, pitch, yaw, point_x, point_y, point_z, output ready);
endinterface

interface epr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [epr_pkg::PT_W-1:0]      rot_w;
  logic signed [epr_pkg::PT_W-1:0]      rot_x;
  logic signed [epr_pkg::PT_W-1:0]      rot_y;
  logic signed [epr_pkg::PT_W-1:0]      rot_z;
  modport source (output valid, rot_w, rot_x, rot_y, rot_z, input ready);
  modport sink   (input valid, rot_w, rot_x, rot_y, rot_z, output ready);
endinterface

// ===== src/epr_cordic.sv =====
// ----------------------------------------------------------------------------
// epr_cordic
// Pipelined rotation-mode CORDIC giving sine and cosine of half an angle.
// ----------------------------------------------------------------------------
module epr_cordic (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [epr_pkg::ANG_W-1:0]  angle_i,
  output logic signed [epr_pkg::QW-1:0]     sin_o,
  output logic signed [epr_pkg::QW-1:0]     cos_o
);

  localparam int N = epr_pkg::NUM_STAGES;

  logic signed [epr_pkg::AW-1:0] a_q [0:N];
  logic signed [epr_pkg::QW-1:0] x_q [0:N];
  logic signed [epr_pkg::QW-1:0] y_q [0:N];
  logic                          flip_q [0:N];
  logic signed [epr_pkg::AW-1:0] half_d;
  logic signed [epr_pkg::QW-1:0] sin_q, cos_q;

  assign half_d = epr_pkg::AW'(angle_i) <<< 17;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= epr_pkg::Q30_GAIN;
      y_q[0] <= '0;
      if (half_d > epr_pkg::Q30_HALF_PI) begin
        a_q[0]    <= half_d - epr_pkg::Q30_PI;
        flip_q[0] <= 1'b1;
      end else if (half_d < -epr_pkg::Q30_HALF_PI) begin
        a_q[0]    <= half_d + epr_pkg::Q30_PI;
        flip_q[0] <= 1'b1;
      end else begin
        a_q[0]    <= half_d;
        flip_q[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (!a_q[i][epr_pkg::AW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          a_q[i+1] <= a_q[i] - epr_pkg::atan_q30(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          a_q[i+1] <= a_q[i] + epr_pkg::atan_q30(5'(i));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= flip_q[N] ? -y_q[N] : y_q[N];
      cos_q <= flip_q[N] ? -x_q[N] : x_q[N];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== src/euler_point_rotation_core.sv =====
// ----------------------------------------------------------------------------
// euler_point_rotation_core
// Rotates a point by the quaternion built from roll, pitch and yaw angles.
// ----------------------------------------------------------------------------
// Fully pipelined: one word is taken every cycle while the output is not
// stalled. The pipeline is the unrolled CORDIC, one stage per iteration,
// followed by eight stages of multiply, round and sum for the quaternion
// products. A stalled output holds the whole pipeline; no word is dropped.
module euler_point_rotation_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  epr_in_if.sink     in_i,
  epr_out_if.source  out_o
);

  localparam int N   = epr_pkg::NUM_STAGES;
  localparam int CL  = N + 2;       // cordic latency
  localparam int PD  = CL + 4;      // point delay to the first hamilton product
  localparam int LAT = CL + 8;
  localparam int QW  = epr_pkg::QW;
  localparam int TW  = epr_pkg::TW;
  localparam int RW  = epr_pkg::RW;
  localparam int PW  = epr_pkg::PT_W;

  logic en;
  logic [LAT-1:0] vld_q;

  logic signed [QW-1:0] sr, cr, sp, cp, sy, cy;
  logic signed [PW-1:0] px_q [0:PD-1];
  logic signed [PW-1:0] py_q [0:PD-1];
  logic signed [PW-1:0] pz_q [0:PD-1];

  logic signed [2*QW-1:0] m1_q [0:3];
  logic signed [QW-1:0]   r1_q [0:3];
  logic signed [QW-1:0]   cy_q, sy_q, cy2_q, sy2_q;
  logic signed [2*QW-1:0] m2_q [0:7];
  logic signed [QW-1:0]   q_q [0:3];
  logic signed [QW-1:0]   qh_q [0:3];
  logic signed [QW-1:0]   qt_q [0:3];
  logic signed [QW+PW-1:0] h1_q [0:11];
  logic signed [TW-1:0]   t_q [0:3];
  logic signed [TW+QW-1:0] h2_q [0:15];
  logic signed [PW-1:0]   rw_q, rx_q, ry_q, rz_q;

  assign en         = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  epr_cordic u_roll  (.clk_i, .en_i(en), .angle_i(in_i.roll),  .sin_o(sr), .cos_o(cr));
  epr_cordic u_pitch (.clk_i, .en_i(en), .angle_i(in_i.pitch), .sin_o(sp), .cos_o(cp));
  epr_cordic u_yaw   (.clk_i, .en_i(en), .angle_i(in_i.yaw),   .sin_o(sy), .cos_o(cy));

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q[0] <= in_i.point_x;
      py_q[0] <= in_i.point_y;
      pz_q[0] <= in_i.point_z;
      for (int k = 1; k < PD; k++) begin
        px_q[k] <= px_q[k-1];
        py_q[k] <= py_q[k-1];
        pz_q[k] <= pz_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // products of roll and pitch terms
      m1_q[0] <= cr * cp;
      m1_q[1] <= sr * sp;
      m1_q[2] <= sr * cp;
      m1_q[3] <= cr * sp;
      cy_q    <= cy;
      sy_q    <= sy;
      // round
      for (int k = 0; k < 4; k++) begin
        r1_q[k] <= QW'(epr_pkg::round30(RW'(m1_q[k])));
      end
      cy2_q <= cy_q;
      sy2_q <= sy_q;
      // multiply by yaw terms
      m2_q[0] <= r1_q[0] * cy2_q;   // cc*cy
      m2_q[1] <= r1_q[1] * sy2_q;   // ss*sy
      m2_q[2] <= r1_q[2] * cy2_q;   // sc*cy
      m2_q[3] <= r1_q[3] * sy2_q;   // cs*sy
      m2_q[4] <= r1_q[3] * cy2_q;   // cs*cy
      m2_q[5] <= r1_q[2] * sy2_q;   // sc*sy
      m2_q[6] <= r1_q[0] * sy2_q;   // cc*sy
      m2_q[7] <= r1_q[1] * cy2_q;   // ss*cy
      // quaternion
      for (int k = 0; k < 4; k++) begin
        if (k == 1 || k == 3) begin
          q_q[k] <= QW'(epr_pkg::round30(RW'(m2_q[2*k]))
                      - epr_pkg::round30(RW'(m2_q[2*k+1])));
        end else begin
          q_q[k] <= QW'(epr_pkg::round30(RW'(m2_q[2*k]))
                      + epr_pkg::round30(RW'(m2_q[2*k+1])));
        end
      end
      // q * p
      h1_q[0]  <= q_q[1] * px_q[PD-1];
      h1_q[1]  <= q_q[2] * py_q[PD-1];
      h1_q[2]  <= q_q[3] * pz_q[PD-1];
      h1_q[3]  <= q_q[0] * px_q[PD-1];
      h1_q[4]  <= q_q[2] * pz_q[PD-1];
      h1_q[5]  <= q_q[3] * py_q[PD-1];
      h1_q[6]  <= q_q[0] * py_q[PD-1];
      h1_q[7]  <= q_q[1] * pz_q[PD-1];
      h1_q[8]  <= q_q[3] * px_q[PD-1];
      h1_q[9]  <= q_q[0] * pz_q[PD-1];
      h1_q[10] <= q_q[1] * py_q[PD-1];
      h1_q[11] <= q_q[2] * px_q[PD-1];
      for (int k = 0; k < 4; k++) begin
        qh_q[k] <= q_q[k];
        qt_q[k] <= qh_q[k];
      end
      t_q[0] <= TW'(epr_pkg::round30(-RW'(h1_q[0]) - RW'(h1_q[1]) - RW'(h1_q[2])));
      t_q[1] <= TW'(epr_pkg::round30(RW'(h1_q[3]) + RW'(h1_q[4]) - RW'(h1_q[5])));
      t_q[2] <= TW'(epr_pkg::round30(RW'(h1_q[6]) - RW'(h1_q[7]) + RW'(h1_q[8])));
      t_q[3] <= TW'(epr_pkg::round30(RW'(h1_q[9]) + RW'(h1_q[10]) - RW'(h1_q[11])));
      // t * conj(q)
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) begin
          h2_q[4*j+k] <= t_q[j] * qt_q[k];
        end
      end
      rw_q <= epr_pkg::sat32(epr_pkg::round30(RW'(h2_q[0]) + RW'(h2_q[5])
                + RW'(h2_q[10]) + RW'(h2_q[15])));
      rx_q <= epr_pkg::sat32(epr_pkg::round30(-RW'(h2_q[1]) + RW'(h2_q[4])
                - RW'(h2_q[11]) + RW'(h2_q[14])));
      ry_q <= epr_pkg::sat32(epr_pkg::round30(-RW'(h2_q[2]) + RW'(h2_q[7])
                + RW'(h2_q[8]) - RW'(h2_q[13])));
      rz_q <= epr_pkg::sat32(epr_pkg::round30(-RW'(h2_q[3]) - RW'(h2_q[6])
                + RW'(h2_q[9]) + RW'(h2_q[12])));
    end
  end

  assign out_o.valid = vld_q[LAT-1];
  assign out_o.rot_w = rw_q;
  assign out_o.rot_x = rx_q;
  assign out_o.rot_y = ry_q;
  assign out_o.rot_z = rz_q;

endmodule
